// File: rtl/png_scanline_unfilter_top_assert.svh
// Assertion macros for the scanline unfilter checker
`ifndef PNG_SCANLINE_UNFILTER_TOP_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PNGUNF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pngunf: assertion failed");

// next-cycle implication
`define PNGUNF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pngunf: assertion failed");

`endif

// File: rtl/pngunf_pkg.sv
// Shared types, constants and the Paeth predictor for the scanline unfilter
package pngunf_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  localparam int BPP_W  = 4;
  localparam int ROWB_W = 13;
  localparam int ROWC_W = 24;
  localparam int CFG_DW = 24;
  localparam int CFG_IW = 2;

  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  typedef enum logic [CFG_IW-1:0] {
    CFG_BPP       = 2'd0,
    CFG_ROW_BYTES = 2'd1,
    CFG_ROW_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  typedef struct packed {
    logic [7:0] data;
    filt_e      filt;
    logic       bad;
    logic       first_row;
    logic       row_end;
    logic       image_end;
  } item_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [9:0] sab;
    logic [9:0] c2;
    logic [7:0] pick;
    pa  = (b > c) ? 10'(b - c) : 10'(c - b);
    pb  = (a > c) ? 10'(a - c) : 10'(c - a);
    sab = 10'(a) + 10'(b);
    c2  = {1'b0, c, 1'b0};
    pc  = (sab > c2) ? (sab - c2) : (c2 - sab);
    if ((pa <= pb) && (pa <= pc)) begin
      pick = a;
    end else if (pb <= pc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

// File: rtl/pngunf_ctrl.sv
// Input side: config registers, row and column counters, row memory read issue
module pngunf_ctrl #(
  parameter int MAX_ROW_BYTES   = pngunf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pngunf_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int AW = $clog2(MAX_ROW_BYTES),
  parameter int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pngunf_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [pngunf_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          s1_adv_i,
  output logic                          rd_en_o,
  output logic [AW-1:0]                 rd_addr_o,
  output logic                          s1_valid_o,
  output pngunf_pkg::item_t             s1_item_o,
  output logic [AW-1:0]                 s1_addr_o,
  output logic                          hist_clr_o,
  output logic [HW-1:0]                 hist_sel_o
);
  import pngunf_pkg::*;

  localparam int CW = $clog2(MAX_ROW_BYTES + 1);

  logic [BPP_W-1:0]  bpp_q;
  logic [ROWB_W-1:0] rowb_q;
  logic [ROWC_W-1:0] rowc_q;
  logic [CW-1:0]     col_q;
  logic [ROWC_W-1:0] row_q;
  filt_e             filt_q;
  logic              bad_q;
  logic              s1_valid_q;
  item_t             s1_item_q;
  logic [AW-1:0]     s1_addr_q;

  logic [BPP_W-1:0]  bpp_eff;
  logic [CW-1:0]     rb_eff;
  logic [ROWC_W-1:0] rc_eff;
  logic              accept;
  logic              is_hdr;
  logic [AW-1:0]     idx;
  logic              last_in_row;
  logic              last_row;
  item_t             item_d;

  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (int'(bpp_q) > MAX_PIXEL_BYTES) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_q;
    end
    if (rowb_q == '0) begin
      rb_eff = CW'(1);
    end else if (int'(rowb_q) > MAX_ROW_BYTES) begin
      rb_eff = CW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = CW'(rowb_q);
    end
    rc_eff = (rowc_q == '0) ? ROWC_W'(1) : rowc_q;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !s1_valid_q || s1_adv_i;
  assign accept      = in_valid_i && in_ready_o;
  assign is_hdr      = (col_q == '0);
  assign idx         = AW'(col_q - CW'(1));
  assign last_in_row = (col_q >= rb_eff);
  assign last_row    = last_in_row &&
                       (({1'b0, row_q} + (ROWC_W + 1)'(1)) >= {1'b0, rc_eff});

  always_comb begin
    item_d.data      = data_byte_i;
    item_d.filt      = filt_q;
    item_d.bad       = bad_q;
    item_d.first_row = (row_q == '0);
    item_d.row_end   = last_in_row;
    item_d.image_end = last_row;
  end

  assign rd_en_o    = accept && !is_hdr;
  assign rd_addr_o  = idx;
  assign hist_clr_o = accept && is_hdr;
  assign hist_sel_o = HW'(bpp_eff - BPP_W'(1));
  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;
  assign s1_addr_o  = s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q  <= BPP_W'(1);
      rowb_q <= ROWB_W'(1);
      rowc_q <= ROWC_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BPP:       bpp_q  <= cfg_data_i[BPP_W-1:0];
        CFG_ROW_BYTES: rowb_q <= cfg_data_i[ROWB_W-1:0];
        CFG_ROW_COUNT: rowc_q <= cfg_data_i[ROWC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      filt_q <= FILT_NONE;
      bad_q  <= 1'b0;
    end else if (accept) begin
      if (is_hdr) begin
        col_q <= CW'(1);
        if (data_byte_i > FILT_MAX_CODE) begin
          filt_q <= FILT_NONE;
          bad_q  <= 1'b1;
        end else begin
          filt_q <= filt_e'(data_byte_i[2:0]);
          bad_q  <= 1'b0;
        end
      end else if (last_in_row) begin
        col_q <= '0;
        row_q <= last_row ? '0 : (row_q + ROWC_W'(1));
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && !is_hdr) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_hdr) begin
      s1_item_q <= item_d;
      s1_addr_q <= idx;
    end
  end

endmodule

// File: rtl/pngunf_row_mem.sv
// Prior-row byte store: one write port, one registered read port
module pngunf_row_mem #(
  parameter int DEPTH = pngunf_pkg::MAX_ROW_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/pngunf_recon.sv
// Byte reconstruction, left and upper-left histories, output register
module pngunf_recon #(
  parameter int MAX_PIXEL_BYTES = pngunf_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int AW = 12,
  parameter int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s1_valid_i,
  input  pngunf_pkg::item_t s1_item_i,
  input  logic [AW-1:0]     s1_addr_i,
  input  logic [7:0]        rd_data_i,
  input  logic              hist_clr_i,
  input  logic [HW-1:0]     hist_sel_i,
  output logic              s1_adv_o,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [7:0]        wr_data_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        pixel_byte_o,
  output logic              row_end_o,
  output logic              image_end_o,
  output logic              bad_filter_o
);
  import pngunf_pkg::*;

  logic [7:0] left_q [MAX_PIXEL_BYTES];
  logic [7:0] upl_q  [MAX_PIXEL_BYTES];
  logic       out_valid_q;
  logic [7:0] pixel_q;
  logic       row_end_q;
  logic       image_end_q;
  logic       bad_q;

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] sum_ab;
  logic [7:0] raw;

  assign a      = left_q[hist_sel_i];
  assign b      = s1_item_i.first_row ? 8'h00 : rd_data_i;
  assign c      = s1_item_i.first_row ? 8'h00 : upl_q[hist_sel_i];
  assign sum_ab = 9'(a) + 9'(b);

  always_comb begin
    case (s1_item_i.filt)
      FILT_NONE:  raw = s1_item_i.data;
      FILT_SUB:   raw = s1_item_i.data + a;
      FILT_UP:    raw = s1_item_i.data + b;
      FILT_AVG:   raw = s1_item_i.data + sum_ab[8:1];
      FILT_PAETH: raw = s1_item_i.data + paeth(a, b, c);
      default:    raw = s1_item_i.data;
    endcase
  end

  assign s1_adv_o  = s1_valid_i && (!out_valid_q || out_ready_i);
  assign wr_en_o   = s1_adv_o;
  assign wr_addr_o = s1_addr_i;
  assign wr_data_o = raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i] <= 8'h00;
        upl_q[i]  <= 8'h00;
      end
    end else if (hist_clr_i) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i] <= 8'h00;
        upl_q[i]  <= 8'h00;
      end
    end else if (s1_adv_o) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_q[i] <= left_q[i-1];
        upl_q[i]  <= upl_q[i-1];
      end
      left_q[0] <= raw;
      upl_q[0]  <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_o) begin
      pixel_q     <= raw;
      row_end_q   <= s1_item_i.row_end;
      image_end_q <= s1_item_i.image_end;
      bad_q       <= s1_item_i.bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign row_end_o    = row_end_q;
  assign image_end_o  = image_end_q;
  assign bad_filter_o = bad_q;

endmodule

// File: rtl/png_scanline_unfilter_top.sv
// PNG scanline unfilter top level: ties input control, row memory and reconstruction
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / data_byte_i) carries the inflated
//   stream: per row one filter-type byte, then row_bytes filtered bytes.
//   Output channel (out_valid_o / out_ready_i) returns one transaction per data
//   byte with pixel_byte_o, row_end_o, image_end_o and bad_filter_o; the
//   filter-type byte produces no output transaction.
//   Config channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   bytes_per_pixel (0), row_bytes (1), row_count (2); always ready. Write only
//   while no data is in flight.
//   A data byte accepted on the input is registered in the input stage while
//   the row-memory read is registered, then loaded into the output register.
//   Throughput: one byte per cycle while the output is not stalled, set by the
//   read/modify/write of the prior-row memory (one read and one write port).
//   Stall: the output register holds while out_ready_i is low; the reconstruct
//   stage then holds and in_ready_o drops until the output register drains.
//   Reset: counters expect a filter byte on the first row, histories clear,
//   config returns to 1/1/1; the row memory is not cleared.
module png_scanline_unfilter_top #(
  parameter int MAX_ROW_BYTES   = pngunf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pngunf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pngunf_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [pngunf_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    pixel_byte_o,
  output logic                          row_end_o,
  output logic                          image_end_o,
  output logic                          bad_filter_o
);
  import pngunf_pkg::*;

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic          s1_adv;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          s1_valid;
  item_t         s1_item;
  logic [AW-1:0] s1_addr;
  logic          hist_clr;
  logic [HW-1:0] hist_sel;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  pngunf_ctrl #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .AW             (AW),
    .HW             (HW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .s1_adv_i   (s1_adv),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item),
    .s1_addr_o  (s1_addr),
    .hist_clr_o (hist_clr),
    .hist_sel_o (hist_sel)
  );

  pngunf_row_mem #(
    .DEPTH(MAX_ROW_BYTES),
    .AW   (AW)
  ) u_row_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  pngunf_recon #(
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .AW             (AW),
    .HW             (HW)
  ) u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_item_i   (s1_item),
    .s1_addr_i   (s1_addr),
    .rd_data_i   (rd_data),
    .hist_clr_i  (hist_clr),
    .hist_sel_i  (hist_sel),
    .s1_adv_o    (s1_adv),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_byte_o(pixel_byte_o),
    .row_end_o   (row_end_o),
    .image_end_o (image_end_o),
    .bad_filter_o(bad_filter_o)
  );

endmodule

// File: rtl/pngunf_checker.sv
// Port-level assertion checker for the scanline unfilter, bound to the top level
`include "png_scanline_unfilter_top_assert.svh"

module pngunf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] pixel_byte_o,
  input logic       row_end_o,
  input logic       image_end_o,
  input logic       bad_filter_o
);

  logic out_txn;
  logic prev_row_end_q;
  logic prev_bad_q;

  assign out_txn = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_end_q <= 1'b1;
      prev_bad_q     <= 1'b0;
    end else if (out_txn) begin
      prev_row_end_q <= row_end_o;
      prev_bad_q     <= bad_filter_o;
    end
  end

  `PNGUNF_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(pixel_byte_o) && $stable(row_end_o) && $stable(image_end_o)
    && $stable(bad_filter_o))
  `PNGUNF_ASSERT(a_ready_when_empty, !out_valid_o, in_ready_o)
  `PNGUNF_ASSERT(a_out_from_input, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2))
  `PNGUNF_ASSERT(a_bad_steady_in_row, out_txn && !prev_row_end_q, bad_filter_o == prev_bad_q)

endmodule

bind png_scanline_unfilter_top pngunf_checker u_pngunf_checker (.*);

// File: tb/png_scanline_unfilter_top_test.sv
// Self-checking testbench for the PNG scanline unfilter top level
`timescale 1ns / 1ps

module png_scanline_unfilter_top_test;
  import pngunf_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int RANDOM_ITEMS    = 600;
  localparam int HOLD_OFF_AT     = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 5;
  localparam int DRAIN_CYCLES    = 10;
  localparam int MAX_PRINTED     = 40;
  localparam logic [7:0] FILT_WORST_CODE = 8'hFF;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad;
  } pixel_out_t;

  class unfilter_scoreboard;
    logic [7:0]  prior_row [MAX_ROW_BYTES_DEF];
    logic [7:0]  left_hist [MAX_PIXEL_BYTES_DEF];
    logic [7:0]  upleft_hist [MAX_PIXEL_BYTES_DEF];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned written_hi;
    logic [7:0]  row_filt;
    logic [BPP_W-1:0]  bpp_reg;
    logic [ROWB_W-1:0] rowb_reg;
    logic [ROWC_W-1:0] rowc_reg;
    pixel_out_t  expected_q [$];
    int          errors;
    int          results_seen;

    function new();
      foreach (prior_row[i]) prior_row[i] = '0;
      clear_hist();
      col_pos      = 0;
      row_pos      = 0;
      written_hi   = 0;
      row_filt     = '0;
      bpp_reg      = 1;
      rowb_reg     = 1;
      rowc_reg     = 1;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void clear_hist();
      foreach (left_hist[i]) begin
        left_hist[i]   = '0;
        upleft_hist[i] = '0;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DW-1:0] value);
      case (idx)
        CFG_BPP:       bpp_reg  = value[BPP_W-1:0];
        CFG_ROW_BYTES: rowb_reg = value[ROWB_W-1:0];
        CFG_ROW_COUNT: rowc_reg = value[ROWC_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned row_len();
      if (rowb_reg == 0) return 1;
      if (rowb_reg > MAX_ROW_BYTES_DEF) return MAX_ROW_BYTES_DEF;
      return rowb_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [7:0] nearest_neighbor(int a, int b, int c);
      int pa;
      int pb;
      int pc;
      pa = (b > c) ? b - c : c - b;
      pb = (a > c) ? a - c : c - a;
      pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
      if (pa <= pb && pa <= pc) return 8'(a);
      if (pb <= pc) return 8'(b);
      return 8'(c);
    endfunction

    function void note_input(logic [7:0] x);
      int unsigned stride;
      int unsigned rows;
      int unsigned idx;
      int          a;
      int          b;
      int          c;
      logic [7:0]  raw;
      bit          last_col;
      bit          last_row;
      pixel_out_t  item;
      if (col_pos == 0) begin
        row_filt = x;
        clear_hist();
        col_pos = 1;
        return;
      end
      stride = (bpp_reg == 0) ? 1 :
               ((bpp_reg > MAX_PIXEL_BYTES_DEF) ? MAX_PIXEL_BYTES_DEF : bpp_reg);
      rows = (rowc_reg == 0) ? 1 : rowc_reg;
      idx  = col_pos - 1;
      if (idx >= MAX_ROW_BYTES_DEF) idx = MAX_ROW_BYTES_DEF - 1;
      a = left_hist[stride - 1];
      b = (row_pos == 0) ? 0 : prior_row[idx];
      c = (row_pos == 0) ? 0 : upleft_hist[stride - 1];
      if (row_filt > FILT_MAX_CODE) begin
        raw = x;
      end else begin
        case (filt_e'(row_filt[2:0]))
          FILT_SUB:   raw = x + 8'(a);
          FILT_UP:    raw = x + 8'(b);
          FILT_AVG:   raw = x + 8'((a + b) >> 1);
          FILT_PAETH: raw = x + nearest_neighbor(a, b, c);
          default:    raw = x;
        endcase
      end
      for (int i = MAX_PIXEL_BYTES_DEF - 1; i > 0; i--) begin
        left_hist[i]   = left_hist[i - 1];
        upleft_hist[i] = upleft_hist[i - 1];
      end
      left_hist[0]   = raw;
      upleft_hist[0] = 8'(b);
      prior_row[idx] = raw;
      if (idx + 1 > written_hi) written_hi = idx + 1;
      last_col = (idx + 1 >= row_len());
      last_row = last_col && (row_pos + 1 >= rows);
      item.pixel     = raw;
      item.row_end   = last_col;
      item.image_end = last_row;
      item.bad       = (row_filt > FILT_MAX_CODE);
      expected_q.push_back(item);
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : (row_pos + 1) % (1 << ROWC_W);
      end else begin
        col_pos = (col_pos + 1) % (1 << ROWB_W);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_result(pixel_out_t got);
      pixel_out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d: pixel %02h with nothing expected",
                         results_seen, got.pixel));
        return;
      end
      want = expected_q.pop_front();
      if (got.pixel !== want.pixel)
        report($sformatf("result %0d: pixel_byte %02h, want %02h",
                         results_seen, got.pixel, want.pixel));
      if (got.row_end !== want.row_end)
        report($sformatf("result %0d: row_end %b, want %b",
                         results_seen, got.row_end, want.row_end));
      if (got.image_end !== want.image_end)
        report($sformatf("result %0d: image_end %b, want %b",
                         results_seen, got.image_end, want.image_end));
      if (got.bad !== want.bad)
        report($sformatf("result %0d: bad_filter %b, want %b",
                         results_seen, got.bad, want.bad));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        data_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        pixel_byte_o;
  logic              row_end_o;
  logic              image_end_o;
  logic              bad_filter_o;

  unfilter_scoreboard sb = new();
  bit          tx_burst;
  bit          rx_burst;
  int unsigned fed_items;
  int unsigned cycle_count;

  png_scanline_unfilter_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_byte_o (pixel_byte_o),
    .row_end_o    (row_end_o),
    .image_end_o  (image_end_o),
    .bad_filter_o (bad_filter_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int idle_cycles(bit burst);
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic push_byte(input logic [7:0] value);
    int gap;
    gap = idle_cycles(tx_burst);
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(value);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic feed_rows(input int rows);
    int unsigned len;
    logic [7:0]  filt;
    for (int r = 0; r < rows; r++) begin
      len  = sb.row_len();
      filt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(FILT_MAX_CODE + 1, 255))
                                         : 8'($urandom_range(0, FILT_MAX_CODE));
      push_byte(filt);
      repeat (len) push_byte(8'($urandom));
      fed_items += len + 1;
    end
  endtask

  initial begin : result_sink
    int gap;
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && sb.results_seen >= HOLD_OFF_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      gap = idle_cycles(rx_burst);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result({pixel_byte_o, row_end_o, image_end_o, bad_filter_o});
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("png_scanline_unfilter_top_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  dir_bytes [12] = '{8'hFF, 8'h80, 8'h01, 8'h01, 8'hFF, 8'h80,
                                    8'hFF, 8'hFF, 8'h80, 8'h80, 8'h7F, 8'hFF};
    filt_e       dir_filt [4] = '{FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH};
    int          phase;
    int unsigned bpp_v;
    int unsigned rowb_v;
    int unsigned rowc_v;
    int unsigned rb_cap;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_BPP;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    fed_items   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_byte(8'(FILT_NONE));
    push_byte(8'hFF);
    push_byte(FILT_WORST_CODE);
    push_byte(8'h00);
    settle();
    set_reg(CFG_BPP, 2);
    set_reg(CFG_ROW_BYTES, 3);
    set_reg(CFG_ROW_COUNT, 4);
    for (int r = 0; r < 4; r++) begin
      push_byte(8'(dir_filt[r]));
      for (int k = 0; k < 3; k++) push_byte(dir_bytes[3 * r + k]);
    end
    settle();
    set_reg(CFG_BPP, CFG_DW'(MAX_PIXEL_BYTES_DEF));
    set_reg(CFG_ROW_BYTES, 8);
    set_reg(CFG_ROW_COUNT, 1);
    push_byte(8'(FILT_PAETH));
    for (int k = 0; k < 4; k++) push_byte(dir_bytes[k + 6]);
    settle();
    // shrink the row under way: the next byte closes it
    set_reg(CFG_ROW_BYTES, 2);
    push_byte(8'h5A);
    settle();

    // widest rows, both registers beyond their saturation points
    tx_burst = $urandom_range(0, 1);
    set_reg(CFG_BPP, {20'($urandom), 4'hF});
    set_reg(CFG_ROW_BYTES, {11'($urandom), 13'h1FFF});
    set_reg(CFG_ROW_COUNT, 2);
    feed_rows(2);

    fed_items = 0;
    phase     = 0;
    while (fed_items < RANDOM_ITEMS) begin
      settle();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      bpp_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                          : $urandom_range(1, MAX_PIXEL_BYTES_DEF);
      case ($urandom_range(0, 9))
        0:       rowb_v = 0;
        1:       rowb_v = $urandom_range(1, 2);
        default: rowb_v = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 9))
        0:       rowc_v = 0;
        1:       rowc_v = $urandom_range(1, (1 << ROWC_W) - 1);
        default: rowc_v = $urandom_range(1, 4);
      endcase
      // keep reads of the row above inside what has been written since reset
      rb_cap = (sb.row_pos == 0) ? (1 << ROWB_W) - 1 : sb.written_hi;
      if (rowb_v > rb_cap) rowb_v = rb_cap;
      if (phase == 0 || $urandom_range(0, 2) != 0)
        set_reg(CFG_BPP, {20'($urandom), 4'(bpp_v)});
      if (phase == 0 || $urandom_range(0, 2) != 0)
        set_reg(CFG_ROW_BYTES, {11'($urandom), 13'(rowb_v)});
      if (phase == 0 || $urandom_range(0, 2) != 0)
        set_reg(CFG_ROW_COUNT, 24'(rowc_v));
      feed_rows($urandom_range(1, 6));
      phase++;
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("png_scanline_unfilter_top_test OK");
    end else begin
      $display("png_scanline_unfilter_top_test NOT OK");
    end
    $finish;
  end

endmodule
